// ===== hw/rtl/she_pkg.sv =====
// ----------------------------------------------------------------------------
// she_pkg
// Shared types, constants and tables of the spherical harmonic evaluator:
// Legendre coefficient ROM, CORDIC arctangent table, prefactor table,
// controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package she_pkg;

	localparam int MAX_DEGREE      = 8;
	localparam int ANGLE_BITS_DEF  = 16;
	localparam int RESULT_BITS_DEF = 32;

	localparam int ROM_DEPTH     = 45;
	localparam int CORDIC_STEPS  = 28;
	localparam int MUL_CHUNKS    = 3;
	localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
	localparam logic [63:0] INV_SQRT_PI_Q30 = 64'd605793953;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_COR_INIT,
		S_COR_RUN,
		S_COR_END,
		S_HORN_INIT,
		S_MUL_LOAD,
		S_MUL_RUN,
		S_MUL_END,
		S_OUT
	} she_state_t;

	typedef enum logic [1:0] {
		OP_HORNER,
		OP_PREF,
		OP_SIN,
		OP_AZI
	} she_op_t;

	typedef struct packed {
		logic       load;
		logic       cor_init;
		logic       cor_step;
		logic       cor_end;
		logic       cor_pass;
		logic       horner_init;
		logic       mul_load;
		logic       mul_step;
		logic       mul_end;
		she_op_t    op;
		logic [1:0] chunk;
		logic [4:0] step;
		logic       out_load;
	} she_cmd_t;

	typedef struct packed {
		logic       invalid;
		logic [3:0] d;
		logic [3:0] ma;
		logic       out_free;
	} she_stat_t;

	typedef struct packed {
		logic        neg;
		logic [1:0]  num;
		logic [3:0]  shift;
		logic [1:0]  kpi;
		logic [14:0] rad;
		logic [8:0][15:0] poly;
	} she_rom_t;

	typedef logic [35:0] she_pref_tab_t [ROM_DEPTH];

	function automatic she_rom_t mk(input int neg, input int num, input int shift,
			input int kpi, input int rad, input int p0, input int p1, input int p2,
			input int p3, input int p4, input int p5, input int p6, input int p7,
			input int p8);
		she_rom_t e;
		e.neg     = neg[0];
		e.num     = num[1:0];
		e.shift   = shift[3:0];
		e.kpi     = kpi[1:0];
		e.rad     = rad[14:0];
		e.poly[0] = p0[15:0];
		e.poly[1] = p1[15:0];
		e.poly[2] = p2[15:0];
		e.poly[3] = p3[15:0];
		e.poly[4] = p4[15:0];
		e.poly[5] = p5[15:0];
		e.poly[6] = p6[15:0];
		e.poly[7] = p7[15:0];
		e.poly[8] = p8[15:0];
		return e;
	endfunction

	function automatic she_rom_t rom_entry(input logic [5:0] idx);
		she_rom_t e;
		case (idx)
			6'd0:  e = mk(0,1,1,1,1,     1,0,0,0,0,0,0,0,0);
			6'd1:  e = mk(0,1,1,1,3,     0,1,0,0,0,0,0,0,0);
			6'd2:  e = mk(1,1,1,2,3,     1,0,0,0,0,0,0,0,0);
			6'd3:  e = mk(0,1,2,1,5,     -1,0,3,0,0,0,0,0,0);
			6'd4:  e = mk(1,1,1,2,15,    0,1,0,0,0,0,0,0,0);
			6'd5:  e = mk(0,1,2,2,15,    1,0,0,0,0,0,0,0,0);
			6'd6:  e = mk(0,1,2,1,7,     0,-3,0,5,0,0,0,0,0);
			6'd7:  e = mk(1,1,3,1,21,    -1,0,5,0,0,0,0,0,0);
			6'd8:  e = mk(0,1,2,2,105,   0,1,0,0,0,0,0,0,0);
			6'd9:  e = mk(1,1,3,1,35,    1,0,0,0,0,0,0,0,0);
			6'd10: e = mk(0,3,4,1,1,     3,0,-30,0,35,0,0,0,0);
			6'd11: e = mk(1,3,3,1,5,     0,-3,0,7,0,0,0,0,0);
			6'd12: e = mk(0,3,3,2,5,     -1,0,7,0,0,0,0,0,0);
			6'd13: e = mk(1,3,3,1,35,    0,1,0,0,0,0,0,0,0);
			6'd14: e = mk(0,3,4,2,35,    1,0,0,0,0,0,0,0,0);
			6'd15: e = mk(0,1,4,1,11,    0,15,0,-70,0,63,0,0,0);
			6'd16: e = mk(1,1,4,2,165,   1,0,-14,0,21,0,0,0,0);
			6'd17: e = mk(0,1,3,2,1155,  0,-1,0,3,0,0,0,0,0);
			6'd18: e = mk(1,1,5,1,385,   -1,0,9,0,0,0,0,0,0);
			6'd19: e = mk(0,3,4,2,385,   0,1,0,0,0,0,0,0,0);
			6'd20: e = mk(1,3,5,1,77,    1,0,0,0,0,0,0,0,0);
			6'd21: e = mk(0,1,5,1,13,    -5,0,105,0,-315,0,231,0,0);
			6'd22: e = mk(1,1,4,2,273,   0,5,0,-30,0,33,0,0,0);
			6'd23: e = mk(0,1,6,1,1365,  1,0,-18,0,33,0,0,0,0);
			6'd24: e = mk(1,1,5,1,1365,  0,-3,0,11,0,0,0,0,0);
			6'd25: e = mk(0,3,5,2,91,    -1,0,11,0,0,0,0,0,0);
			6'd26: e = mk(1,3,5,1,1001,  0,1,0,0,0,0,0,0,0);
			6'd27: e = mk(0,1,6,1,3003,  1,0,0,0,0,0,0,0,0);
			6'd28: e = mk(0,1,5,1,15,    0,-35,0,315,0,-693,0,429,0);
			6'd29: e = mk(1,1,6,2,105,   -5,0,135,0,-495,0,429,0,0);
			6'd30: e = mk(0,3,6,1,35,    0,15,0,-110,0,143,0,0,0);
			6'd31: e = mk(1,3,6,2,35,    3,0,-66,0,143,0,0,0,0);
			6'd32: e = mk(0,3,5,2,385,   0,-3,0,13,0,0,0,0,0);
			6'd33: e = mk(1,3,6,2,385,   -1,0,13,0,0,0,0,0,0);
			6'd34: e = mk(0,3,6,1,5005,  0,1,0,0,0,0,0,0,0);
			6'd35: e = mk(1,3,6,2,715,   1,0,0,0,0,0,0,0,0);
			6'd36: e = mk(0,1,8,1,17,    35,0,-1260,0,6930,0,-12012,0,6435);
			6'd37: e = mk(1,3,6,2,17,    0,-35,0,385,0,-1001,0,715,0);
			6'd38: e = mk(0,3,7,1,595,   -1,0,33,0,-143,0,143,0,0);
			6'd39: e = mk(1,1,6,2,19635, 0,3,0,-26,0,39,0,0,0);
			6'd40: e = mk(0,3,7,2,1309,  1,0,-26,0,65,0,0,0,0);
			6'd41: e = mk(1,3,6,2,17017, 0,-1,0,5,0,0,0,0,0);
			6'd42: e = mk(0,1,7,1,7293,  -1,0,15,0,0,0,0,0,0);
			6'd43: e = mk(1,3,6,2,12155, 0,1,0,0,0,0,0,0,0);
			6'd44: e = mk(0,3,8,2,12155, 1,0,0,0,0,0,0,0,0);
			default: e = mk(0,0,0,1,0,   0,0,0,0,0,0,0,0,0);
		endcase
		return e;
	endfunction

	function automatic logic [5:0] tri_base(input logic [3:0] deg);
		logic [5:0] b;
		case (deg)
			4'd0: b = 6'd0;
			4'd1: b = 6'd1;
			4'd2: b = 6'd3;
			4'd3: b = 6'd6;
			4'd4: b = 6'd10;
			4'd5: b = 6'd15;
			4'd6: b = 6'd21;
			4'd7: b = 6'd28;
			4'd8: b = 6'd36;
			default: b = 6'd0;
		endcase
		return b;
	endfunction

	function automatic logic [29:0] atan_val(input logic [4:0] i);
		logic [29:0] a;
		case (i)
			5'd0:  a = 30'd536870912;
			5'd1:  a = 30'd316933406;
			5'd2:  a = 30'd167458907;
			5'd3:  a = 30'd85004756;
			5'd4:  a = 30'd42667331;
			5'd5:  a = 30'd21354465;
			5'd6:  a = 30'd10679838;
			5'd7:  a = 30'd5340245;
			5'd8:  a = 30'd2670163;
			5'd9:  a = 30'd1335087;
			5'd10: a = 30'd667544;
			5'd11: a = 30'd333772;
			5'd12: a = 30'd166886;
			5'd13: a = 30'd83443;
			5'd14: a = 30'd41722;
			5'd15: a = 30'd20861;
			5'd16: a = 30'd10430;
			5'd17: a = 30'd5215;
			5'd18: a = 30'd2608;
			5'd19: a = 30'd1304;
			5'd20: a = 30'd652;
			5'd21: a = 30'd326;
			5'd22: a = 30'd163;
			5'd23: a = 30'd81;
			5'd24: a = 30'd41;
			5'd25: a = 30'd20;
			5'd26: a = 30'd10;
			5'd27: a = 30'd5;
			default: a = 30'd0;
		endcase
		return a;
	endfunction

	// a/2^b * sqrt(R/(k*pi)) in Q30, evaluated at elaboration
	function automatic logic [35:0] pref_of(input she_rom_t e);
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] bt;
		logic [63:0] res;
		logic [63:0] t;
		int n;
		int f;
		r = 64'(e.rad) * 64'(e.kpi);
		n = 0;
		for (int i = 0; i < 63; i++) begin
			if ((r >> i) != 64'd0) n = i + 1;
		end
		f = (62 - n) >> 1;
		x = r << (2 * f);
		bt = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (bt > x) bt = bt >> 2;
		end
		res = 64'd0;
		for (int i = 0; i < 32; i++) begin
			if (bt != 64'd0) begin
				if (x >= res + bt) begin
					x = x - (res + bt);
					res = (res >> 1) + bt;
				end else begin
					res = res >> 1;
				end
				bt = bt >> 2;
			end
		end
		t = res * INV_SQRT_PI_Q30 * 64'(e.num);
		return 36'(t >> (f + int'(e.shift) + int'(e.kpi) - 1));
	endfunction

	function automatic she_pref_tab_t build_pref();
		she_pref_tab_t tab;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			tab[i] = pref_of(rom_entry(6'(i)));
		end
		return tab;
	endfunction

	localparam she_pref_tab_t PREF_TAB = build_pref();

endpackage

// ===== hw/rtl/she_if.sv =====
// ----------------------------------------------------------------------------
// she_if
// Valid/ready channels of the spherical harmonic evaluator: the angle item
// going in and the result item coming out.
// ----------------------------------------------------------------------------
interface she_in_if #(
	parameter int ANGLE_BITS = 16
);
	logic                  valid;
	logic                  ready;
	logic                  mode;
	logic [3:0]            degree;
	logic signed [4:0]     order;
	logic [ANGLE_BITS-1:0] polar_angle;
	logic [ANGLE_BITS-1:0] azimuth_angle;

	modport source (output valid, output mode, output degree, output order,
		output polar_angle, output azimuth_angle, input ready);
	modport sink (input valid, input mode, input degree, input order,
		input polar_angle, input azimuth_angle, output ready);
endinterface

interface she_out_if #(
	parameter int RESULT_BITS = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [RESULT_BITS-1:0] value;
	logic                          invalid;

	modport source (output valid, output value, output invalid, input ready);
	modport sink (input valid, input value, input invalid, output ready);
endinterface

// ===== hw/rtl/she_ctrl.sv =====
// ----------------------------------------------------------------------------
// she_ctrl
// Sequencer of the evaluator: runs the two CORDIC passes, the Horner,
// prefactor, power and final azimuth multiplies, then hands the result on.
// ----------------------------------------------------------------------------
module she_ctrl import she_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  she_stat_t stat,
	output she_cmd_t  cmd
);

	she_state_t state_q, state_d;
	logic [4:0] cnt_q;
	logic [1:0] chunk_q;
	logic       pass_q;
	she_op_t    op_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:      if (in_valid) state_d = S_CHECK;
			S_CHECK:     state_d = stat.invalid ? S_OUT : S_COR_INIT;
			S_COR_INIT:  state_d = S_COR_RUN;
			S_COR_RUN:   if (cnt_q == 5'(CORDIC_STEPS - 1)) state_d = S_COR_END;
			S_COR_END:   state_d = pass_q ? S_HORN_INIT : S_COR_INIT;
			S_HORN_INIT: state_d = S_MUL_LOAD;
			S_MUL_LOAD:  state_d = S_MUL_RUN;
			S_MUL_RUN:   if (chunk_q == 2'(MUL_CHUNKS - 1)) state_d = S_MUL_END;
			S_MUL_END:   state_d = (op_q == OP_AZI) ? S_OUT : S_MUL_LOAD;
			S_OUT:       if (stat.out_free) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd             = '0;
		cmd.op          = op_q;
		cmd.chunk       = chunk_q;
		cmd.cor_pass    = pass_q;
		cmd.step        = (state_q == S_MUL_END) ? cnt_q - 5'd1 : cnt_q;
		in_ready        = (state_q == S_IDLE);
		case (state_q)
			S_IDLE:      cmd.load = in_valid;
			S_COR_INIT:  cmd.cor_init = 1'b1;
			S_COR_RUN:   cmd.cor_step = 1'b1;
			S_COR_END:   cmd.cor_end = 1'b1;
			S_HORN_INIT: cmd.horner_init = 1'b1;
			S_MUL_LOAD:  cmd.mul_load = 1'b1;
			S_MUL_RUN:   cmd.mul_step = 1'b1;
			S_MUL_END:   cmd.mul_end = 1'b1;
			S_OUT:       cmd.out_load = stat.out_free;
			default:     cmd.load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			chunk_q <= '0;
			pass_q  <= 1'b0;
			op_q    <= OP_HORNER;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE:     pass_q <= 1'b0;
				S_COR_INIT: cnt_q <= '0;
				S_COR_RUN:  cnt_q <= cnt_q + 5'd1;
				S_COR_END:  pass_q <= 1'b1;
				S_HORN_INIT: begin
					cnt_q <= {1'b0, stat.d};
					op_q  <= (stat.d == 4'd0) ? OP_PREF : OP_HORNER;
				end
				S_MUL_LOAD: chunk_q <= '0;
				S_MUL_RUN:  chunk_q <= chunk_q + 2'd1;
				S_MUL_END: begin
					case (op_q)
						OP_HORNER: begin
							cnt_q <= cnt_q - 5'd1;
							if (cnt_q == 5'd1) op_q <= OP_PREF;
						end
						OP_PREF: begin
							cnt_q <= {1'b0, stat.ma};
							op_q  <= (stat.ma == 4'd0) ? OP_AZI : OP_SIN;
						end
						OP_SIN: begin
							cnt_q <= cnt_q - 5'd1;
							if (cnt_q == 5'd1) op_q <= OP_AZI;
						end
						default: op_q <= OP_AZI;
					endcase
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/she_dp.sv =====
// ----------------------------------------------------------------------------
// she_dp
// Datapath of the evaluator: item registers, shared CORDIC rotator, chunked
// Q30 multiplier with Horner accumulate, and the output register.
// ----------------------------------------------------------------------------
module she_dp import she_pkg::*; #(
	parameter int ANGLE_BITS  = ANGLE_BITS_DEF,
	parameter int RESULT_BITS = RESULT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  she_cmd_t                      cmd,
	output she_stat_t                     stat,
	input  logic                          mode,
	input  logic [3:0]                    degree,
	input  logic [4:0]                    order,
	input  logic [ANGLE_BITS-1:0]         polar_angle,
	input  logic [ANGLE_BITS-1:0]         azimuth_angle,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [RESULT_BITS-1:0] out_value,
	output logic                          out_invalid
);

	localparam int SHL = (RESULT_BITS >= 32) ? RESULT_BITS - 32 : 0;
	localparam int SHR = (RESULT_BITS < 32) ? 32 - RESULT_BITS : 0;
	localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (RESULT_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
	localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

	// item registers
	logic        mode_q, ord_neg_q, invalid_q;
	logic [3:0]  ma_q, d_q;
	logic [5:0]  idx_q;
	logic [31:0] pol_q, azi_q;

	// rotator and products
	logic signed [33:0] x_q, y_q;
	logic signed [32:0] z_q;
	logic [1:0]         quad_q;
	logic               zero_q;
	logic signed [31:0] c_q, s_q, cp_q, sp_q;
	logic signed [47:0] acc_q;
	logic [47:0]        mul_a_q;
	logic [35:0]        mul_b_q;
	logic               mul_neg_q;
	logic [83:0]        prod_q;
	logic               out_valid_q, out_invalid_q;
	logic [RESULT_BITS-1:0] out_value_q;

	logic [4:0]  ld_ma;
	logic [31:0] ld_pol, ld_azi;
	she_rom_t    rom_cur;

	always_comb begin
		ld_ma  = order[4] ? (~order + 5'd1) : order;
		ld_pol = 32'(64'(polar_angle) << (32 - ANGLE_BITS));
		ld_azi = 32'(64'(azimuth_angle) << (32 - ANGLE_BITS));
		rom_cur = rom_entry(idx_q);
	end

	// rotator
	logic [31:0]        cor_phase;
	logic signed [33:0] dx, dy, cx, cy;
	logic signed [32:0] at;
	logic signed [31:0] co, si;

	always_comb begin
		cor_phase = cmd.cor_pass ? azi_q : pol_q;
		dx = y_q >>> cmd.step;
		dy = x_q >>> cmd.step;
		at = 33'(atan_val(cmd.step));
		if (x_q > ONE_Q30) cx = ONE_Q30;
		else if (x_q < -ONE_Q30) cx = -ONE_Q30;
		else cx = x_q;
		if (y_q > ONE_Q30) cy = ONE_Q30;
		else if (y_q < -ONE_Q30) cy = -ONE_Q30;
		else cy = y_q;
		if (zero_q) begin
			cx = ONE_Q30;
			cy = '0;
		end
		case (quad_q)
			2'd0: begin co = 32'(cx);  si = 32'(cy);  end
			2'd1: begin co = -32'(cy); si = 32'(cx);  end
			2'd2: begin co = -32'(cx); si = -32'(cy); end
			default: begin co = 32'(cy); si = -32'(cx); end
		endcase
	end

	// multiplier operands
	logic signed [36:0] b_sel;
	logic signed [31:0] t_sel;
	logic [51:0]        pp;
	logic [47:0]        prod_r;
	logic signed [47:0] mul_res;
	logic [15:0]        coef_m, coef_h;

	always_comb begin
		t_sel = mode_q ? sp_q : cp_q;
		if (ord_neg_q && (mode_q ^ ma_q[0])) t_sel = -t_sel;
		case (cmd.op)
			OP_HORNER: b_sel = 37'(c_q);
			OP_PREF:   b_sel = {1'b0, PREF_TAB[idx_q]};
			OP_SIN:    b_sel = 37'(s_q);
			default:   b_sel = 37'(t_sel);
		endcase
		pp      = mul_a_q[{cmd.chunk, 4'b0} +: 16] * mul_b_q;
		prod_r  = prod_q[77:30];
		mul_res = mul_neg_q ? -$signed(prod_r) : $signed(prod_r);
		coef_m  = rom_cur.poly[cmd.step[3:0]];
		coef_h  = rom_cur.poly[d_q];
	end

	// output conversion
	logic signed [63:0] wide, scaled;
	logic [RESULT_BITS-1:0] conv;

	always_comb begin
		wide   = 64'(acc_q);
		scaled = (wide <<< SHL) >>> SHR;
		if (scaled > SAT_HI) conv = RESULT_BITS'(SAT_HI);
		else if (scaled < SAT_LO) conv = RESULT_BITS'(SAT_LO);
		else conv = RESULT_BITS'(scaled);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q    <= mode;
			ord_neg_q <= order[4];
			ma_q      <= ld_ma[3:0];
			d_q       <= degree - ld_ma[3:0];
			idx_q     <= tri_base(degree) + 6'(ld_ma[3:0]);
			invalid_q <= (degree > 4'(MAX_DEGREE)) || ({1'b0, degree} < ld_ma);
			pol_q     <= ld_pol;
			azi_q     <= 32'(36'(ld_azi) * 36'(ld_ma[3:0]));
		end
		if (cmd.cor_init) begin
			x_q    <= $signed(CORDIC_GAIN);
			y_q    <= '0;
			z_q    <= {3'b000, cor_phase[29:0]};
			quad_q <= cor_phase[31:30];
			zero_q <= (cor_phase[29:0] == 30'd0);
		end
		if (cmd.cor_step) begin
			if (!z_q[32]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
		if (cmd.cor_end) begin
			if (cmd.cor_pass) begin
				cp_q <= co;
				sp_q <= si;
			end else begin
				c_q <= co;
				s_q <= si;
			end
		end
		if (cmd.horner_init) acc_q <= {{2{coef_h[15]}}, coef_h, 30'b0};
		if (cmd.mul_load) begin
			mul_a_q   <= acc_q[47] ? 48'(-acc_q) : 48'(acc_q);
			mul_b_q   <= b_sel[36] ? 36'(-b_sel) : 36'(b_sel);
			mul_neg_q <= acc_q[47] ^ b_sel[36] ^ ((cmd.op == OP_AZI) && rom_cur.neg);
			prod_q    <= '0;
		end
		if (cmd.mul_step) prod_q <= prod_q + (84'(pp) << {cmd.chunk, 4'b0});
		if (cmd.mul_end) begin
			if (cmd.op == OP_HORNER) acc_q <= mul_res + {{2{coef_m[15]}}, coef_m, 30'b0};
			else acc_q <= mul_res;
		end
		if (cmd.out_load) begin
			out_value_q   <= invalid_q ? '0 : conv;
			out_invalid_q <= invalid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		stat.invalid  = invalid_q;
		stat.d        = d_q;
		stat.ma       = ma_q;
		stat.out_free = !out_valid_q || out_ready;
	end

	assign out_valid   = out_valid_q;
	assign out_value   = $signed(out_value_q);
	assign out_invalid = out_invalid_q;

endmodule

// ===== hw/rtl/spherical_harmonic_eval.sv =====
// ----------------------------------------------------------------------------
// spherical_harmonic_eval
// Real or imaginary part of the orthonormal spherical harmonic Y(l,m),
// degree 0..8, with Condon-Shortley phase.
// ----------------------------------------------------------------------------
// One item at a time. A valid item goes, from acceptance to result, through
// two 28-step passes of one shared CORDIC rotator (polar angle, then |m|
// times azimuth), followed by l+2 multiplies on one 16x36 chunked
// multiplier (Horner over the Legendre polynomial, prefactor, |m| powers
// of sin(theta), azimuth factor).
// Items with |m| > l or l > 8 go from the check state straight to the output
// state, with value 0 and invalid set. The next item is taken once the result
// sits in the output register, even if it has not been taken yet.
// ----------------------------------------------------------------------------
module spherical_harmonic_eval import she_pkg::*; #(
	parameter int ANGLE_BITS  = ANGLE_BITS_DEF,
	parameter int RESULT_BITS = RESULT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	she_in_if.sink      sample,
	she_out_if.source   result
);

	she_cmd_t  cmd;
	she_stat_t stat;
	logic      in_ready;

	she_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	she_dp #(
		.ANGLE_BITS  (ANGLE_BITS),
		.RESULT_BITS (RESULT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.mode          (sample.mode),
		.degree        (sample.degree),
		.order         (sample.order),
		.polar_angle   (sample.polar_angle),
		.azimuth_angle (sample.azimuth_angle),
		.out_valid     (result.valid),
		.out_ready     (result.ready),
		.out_value     (result.value),
		.out_invalid   (result.invalid)
	);

	assign sample.ready = in_ready;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("second item accepted while one is in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!result.valid || result.ready))
		else $error("pending result overwritten");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.invalid |-> result.value == '0)
		else $error("invalid result carries a nonzero value");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !cmd.out_load)
		else $error("result loaded right after item");

endmodule

// ===== bench/she_scoreboard.sv =====
// ----------------------------------------------------------------------------
// she_scoreboard
// Predicts the spherical harmonic evaluator result for each accepted item,
// in fixed point, and holds the predictions until the results come back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class she_scoreboard;

	typedef struct {
		logic signed [31:0] value;
		logic               invalid;
	} ylm_result_t;

	ylm_result_t pending[$];
	int          mismatches;
	longint      legendre_poly[45][9];
	bit          cs_neg[45];
	longint      pref_q30[45];
	longint      atan_q30[28];

	function new();
		longint rawtab[45][14];
		int     i;
		int     j;
		longint r;
		longint s;
		int     n;
		int     f;
		rawtab = '{
			'{0,1,1,1,1,  1,0,0,0,0,0,0,0,0},
			'{0,1,1,1,3,  0,1,0,0,0,0,0,0,0},
			'{1,1,1,2,3,  1,0,0,0,0,0,0,0,0},
			'{0,1,2,1,5,  -1,0,3,0,0,0,0,0,0},
			'{1,1,1,2,15, 0,1,0,0,0,0,0,0,0},
			'{0,1,2,2,15, 1,0,0,0,0,0,0,0,0},
			'{0,1,2,1,7,  0,-3,0,5,0,0,0,0,0},
			'{1,1,3,1,21, -1,0,5,0,0,0,0,0,0},
			'{0,1,2,2,105, 0,1,0,0,0,0,0,0,0},
			'{1,1,3,1,35, 1,0,0,0,0,0,0,0,0},
			'{0,3,4,1,1,  3,0,-30,0,35,0,0,0,0},
			'{1,3,3,1,5,  0,-3,0,7,0,0,0,0,0},
			'{0,3,3,2,5,  -1,0,7,0,0,0,0,0,0},
			'{1,3,3,1,35, 0,1,0,0,0,0,0,0,0},
			'{0,3,4,2,35, 1,0,0,0,0,0,0,0,0},
			'{0,1,4,1,11, 0,15,0,-70,0,63,0,0,0},
			'{1,1,4,2,165, 1,0,-14,0,21,0,0,0,0},
			'{0,1,3,2,1155, 0,-1,0,3,0,0,0,0,0},
			'{1,1,5,1,385, -1,0,9,0,0,0,0,0,0},
			'{0,3,4,2,385, 0,1,0,0,0,0,0,0,0},
			'{1,3,5,1,77, 1,0,0,0,0,0,0,0,0},
			'{0,1,5,1,13, -5,0,105,0,-315,0,231,0,0},
			'{1,1,4,2,273, 0,5,0,-30,0,33,0,0,0},
			'{0,1,6,1,1365, 1,0,-18,0,33,0,0,0,0},
			'{1,1,5,1,1365, 0,-3,0,11,0,0,0,0,0},
			'{0,3,5,2,91, -1,0,11,0,0,0,0,0,0},
			'{1,3,5,1,1001, 0,1,0,0,0,0,0,0,0},
			'{0,1,6,1,3003, 1,0,0,0,0,0,0,0,0},
			'{0,1,5,1,15, 0,-35,0,315,0,-693,0,429,0},
			'{1,1,6,2,105, -5,0,135,0,-495,0,429,0,0},
			'{0,3,6,1,35, 0,15,0,-110,0,143,0,0,0},
			'{1,3,6,2,35, 3,0,-66,0,143,0,0,0,0},
			'{0,3,5,2,385, 0,-3,0,13,0,0,0,0,0},
			'{1,3,6,2,385, -1,0,13,0,0,0,0,0,0},
			'{0,3,6,1,5005, 0,1,0,0,0,0,0,0,0},
			'{1,3,6,2,715, 1,0,0,0,0,0,0,0,0},
			'{0,1,8,1,17, 35,0,-1260,0,6930,0,-12012,0,6435},
			'{1,3,6,2,17, 0,-35,0,385,0,-1001,0,715,0},
			'{0,3,7,1,595, -1,0,33,0,-143,0,143,0,0},
			'{1,1,6,2,19635, 0,3,0,-26,0,39,0,0,0},
			'{0,3,7,2,1309, 1,0,-26,0,65,0,0,0,0},
			'{1,3,6,2,17017, 0,-1,0,5,0,0,0,0,0},
			'{0,1,7,1,7293, -1,0,15,0,0,0,0,0,0},
			'{1,3,6,2,12155, 0,1,0,0,0,0,0,0,0},
			'{0,3,8,2,12155, 1,0,0,0,0,0,0,0,0}
		};
		atan_q30 = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
			41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};
		for (i = 0; i < 45; i++) begin
			cs_neg[i] = rawtab[i][0] != 0;
			for (j = 0; j < 9; j++)
				legendre_poly[i][j] = rawtab[i][5 + j];
			r = rawtab[i][4] * rawtab[i][3];
			n = 0;
			while (n < 63 && (r >>> n) != 0)
				n++;
			f = (62 - n) / 2;
			s = isqrt(r << (2 * f));
			pref_q30[i] = longint'((64'(s) * 64'd605793953 * 64'(rawtab[i][1]))
				>> (f + rawtab[i][2] + rawtab[i][3] - 1));
		end
		mismatches = 0;
	endfunction

	function longint isqrt(longint xin);
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] bt;
		x = xin;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > x)
			bt >>= 2;
		while (bt != 0) begin
			if (x >= res + bt) begin
				x -= res + bt;
				res = (res >> 1) + bt;
			end else
				res >>= 1;
			bt >>= 2;
		end
		return longint'(res);
	endfunction

	// product of Q30 values, truncated toward zero
	function longint qmul(longint a, longint b);
		logic [127:0] ua;
		logic [127:0] ub;
		logic [127:0] p;
		longint       r;
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		p = (ua * ub) >> 30;
		if (p > 128'h7FFF_FFFF_FFFF_FFFF)
			p = 128'h7FFF_FFFF_FFFF_FFFF;
		r = longint'(p[63:0]);
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function longint clamp_unit(longint v);
		if (v > (64'sd1 << 30))
			return 64'sd1 << 30;
		if (v < -(64'sd1 << 30))
			return -(64'sd1 << 30);
		return v;
	endfunction

	function void rotate(logic [31:0] phase, output longint co, output longint si);
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		int     i;
		x = 64'sd1 << 30;
		y = 0;
		z = phase[29:0];
		if (z != 0) begin
			x = 652032874;
			for (i = 0; i < 28; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= atan_q30[i];
				end else begin
					x += dx;
					y -= dy;
					z += atan_q30[i];
				end
			end
			x = clamp_unit(x);
			y = clamp_unit(y);
		end
		case (phase[31:30])
			2'd0: begin co = x; si = y; end
			2'd1: begin co = -y; si = x; end
			2'd2: begin co = -x; si = -y; end
			default: begin co = y; si = -x; end
		endcase
	endfunction

	function void note_item(logic mode, logic [3:0] degree, logic signed [4:0] order,
			logic [15:0] polar, logic [15:0] azimuth);
		ylm_result_t exp_res;
		int          ma;
		int          idx;
		int          k;
		longint      c;
		longint      s;
		longint      cp;
		longint      sp;
		longint      acc;
		longint      v;
		longint      t;
		logic [31:0] azi_phase;
		ma = order < 0 ? -order : order;
		if (degree > 8 || ma > degree) begin
			exp_res.value = 0;
			exp_res.invalid = 1'b1;
			pending.push_back(exp_res);
			return;
		end
		rotate({polar, 16'd0}, c, s);
		azi_phase = 32'(ma) * {azimuth, 16'd0};
		rotate(azi_phase, cp, sp);
		idx = degree * (degree + 1) / 2 + ma;
		acc = legendre_poly[idx][degree - ma] <<< 30;
		for (k = degree - ma - 1; k >= 0; k--)
			acc = qmul(acc, c) + (legendre_poly[idx][k] <<< 30);
		v = qmul(acc, pref_q30[idx]);
		for (k = 0; k < ma; k++)
			v = qmul(v, s);
		if (cs_neg[idx])
			v = -v;
		t = mode ? sp : cp;
		if (order < 0) begin
			if (mode)
				t = -t;
			if (ma[0])
				t = -t;
		end
		v = qmul(v, t);
		if (v > 64'sd2147483647)
			v = 64'sd2147483647;
		if (v < -64'sd2147483648)
			v = -64'sd2147483648;
		exp_res.value = 32'(v);
		exp_res.invalid = 1'b0;
		pending.push_back(exp_res);
	endfunction

	function void check_result(logic signed [31:0] value, logic invalid);
		ylm_result_t exp_res;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result value=%0d invalid=%0b", value, invalid);
			return;
		end
		exp_res = pending.pop_front();
		if (value !== exp_res.value || invalid !== exp_res.invalid) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected value=%0d invalid=%0b, got value=%0d invalid=%0b",
					exp_res.value, exp_res.invalid, value, invalid);
		end
	endfunction

endclass

// ===== bench/tb_spherical_harmonic_eval.sv =====
// ----------------------------------------------------------------------------
// tb_spherical_harmonic_eval
// Drives directed and random angle items through the evaluator with random
// idling on both channels and checks every result against a fixed-point
// prediction of Y(l,m).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_spherical_harmonic_eval;

	localparam int CYCLE_LIMIT = 1500000;

	logic clk;
	logic arst_n;
	bit   quiet_tail;
	int   cycles;

	she_in_if  #(.ANGLE_BITS(16))  sample();
	she_out_if #(.RESULT_BITS(32)) result();

	spherical_harmonic_eval dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample.sink),
		.result (result.source)
	);

	she_scoreboard ylm_board = new();

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// check results; ready toggles in random bursts
	initial begin
		int stall;
		result.ready = 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result.valid && result.ready)
				ylm_board.check_result(result.value, result.invalid);
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				result.ready = 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 17) - 1;
				result.ready = 1'b0;
			end else
				result.ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_item(logic mode, logic [3:0] degree, logic signed [4:0] order,
			logic [15:0] polar, logic [15:0] azimuth);
		int gap;
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			sample.valid = 1'b0;
			gap = $urandom_range(1, 17);
			repeat (gap) @(negedge clk);
		end
		sample.valid = 1'b1;
		sample.mode = mode;
		sample.degree = degree;
		sample.order = order;
		sample.polar_angle = polar;
		sample.azimuth_angle = azimuth;
		do @(posedge clk); while (!sample.ready);
		ylm_board.note_item(mode, degree, order, polar, azimuth);
		@(negedge clk);
		sample.valid = 1'b0;
	endtask

	task automatic drain();
		while (ylm_board.pending.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int i;
		int l;
		int m;
		cycles = 0;
		quiet_tail = 1'b0;
		arst_n = 1'b0;
		sample.valid = 1'b0;
		sample.mode = 1'b0;
		sample.degree = '0;
		sample.order = '0;
		sample.polar_angle = '0;
		sample.azimuth_angle = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(0, 0, 0, 16'h0000, 16'h0000);
		send_item(1, 0, 0, 16'hFFFF, 16'hFFFF);
		send_item(0, 8, 8, 16'h4000, 16'h2000);
		send_item(1, 8, -8, 16'h1234, 16'hFFFF);
		send_item(0, 8, -8, 16'hFFFF, 16'h8000);
		send_item(1, 3, 0, 16'hA5A5, 16'h5A5A);
		send_item(0, 2, 3, 16'h1000, 16'h1000);
		send_item(0, 9, 0, 16'h1000, 16'h1000);
		send_item(1, 15, -16, 16'hFFFF, 16'hFFFF);
		send_item(0, 0, 15, 16'h0001, 16'h0001);
		send_item(1, 5, -3, 16'h8000, 16'hC000);
		send_item(0, 7, 7, 16'h4000, 16'h4000);
		send_item(1, 6, -1, 16'h5555, 16'hAAAA);
		send_item(0, 4, -2, 16'hC000, 16'h0001);
		send_item(1, 8, 0, 16'h0000, 16'h0000);
		drain();

		for (i = 0; i < 1300; i++) begin
			if (i == 1200)
				quiet_tail = 1'b1;
			if ($urandom_range(0, 9) == 0) begin
				send_item(1'($urandom), 4'($urandom), 5'($urandom), 16'($urandom),
					16'($urandom));
			end else begin
				l = $urandom_range(0, 8);
				m = $urandom_range(0, l);
				if ($urandom_range(0, 1))
					m = -m;
				send_item(1'($urandom), 4'(l), 5'(m), 16'($urandom), 16'($urandom));
			end
			if (i == 600)
				drain();
		end
		drain();
		repeat (200) @(negedge clk);
		if (ylm_board.mismatches == 0 && ylm_board.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/she_pkg.sv
hw/rtl/she_if.sv
hw/rtl/she_ctrl.sv
hw/rtl/she_dp.sv
hw/rtl/spherical_harmonic_eval.sv
bench/she_scoreboard.sv
bench/tb_spherical_harmonic_eval.sv
